// File: rtl/spd_pkg.sv
// Shared types, codes and constants of the sonar packet deframer.
// No dependencies; the controller, datapath, top and testbench take names from here.
`timescale 1ns / 1ps

package spd_pkg;

  localparam int unsigned READINGS_PER_SWEEP = 24;

  // APB register map: one 8-bit register, word index in paddr[2].
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;
  localparam logic [APB_ADDR_W-3:0] REG_MAX_RANGE = '0;
  localparam logic [7:0] MAX_RANGE_RESET = 8'hFF;

  // Packet framing bytes
  localparam logic [7:0] STATION_BYTE = 8'h01;
  localparam logic [7:0] CMD_ACK = 8'h02;
  localparam logic [7:0] CMD_SWEEP = 8'h06;
  localparam logic [15:0] ACK_LEN = 16'd1;

  // Ack response codes
  localparam logic [7:0] ACK_CODE_OK = 8'h00;
  localparam logic [7:0] ACK_CODE_ILLEGAL = 8'h7F;
  localparam logic [7:0] ACK_CODE_BAD_SUM = 8'h7E;

  typedef enum logic [2:0] {
    EV_READING     = 3'd0,
    EV_ACK_OK      = 3'd1,
    EV_ACK_ILLEGAL = 3'd2,
    EV_ACK_BAD_SUM = 3'd3,
    EV_ACK_OTHER   = 3'd4,
    EV_BAD_SUM     = 3'd5,
    EV_BAD_LEN     = 3'd6,
    EV_UNKNOWN_CMD = 3'd7
  } event_e;

  // Outcome of judging a finished packet
  typedef enum logic [1:0] {
    VK_NONE   = 2'd0,
    VK_SINGLE = 2'd1,
    VK_SWEEP  = 2'd2
  } verdict_e;

  typedef struct packed {
    logic sum_start;     // station byte seen: sum restarts at it
    logic sum_add;       // add byte to running sum
    logic ld_cmd;
    logic ld_len_hi;
    logic ld_len_lo;     // also clears byte count and first bytes
    logic pay_byte;      // payload byte
    logic ld_sum_hi;
    logic ld_sum_lo;
    logic frame_update;  // remember the sweep frame number
    logic emit_clear;    // reading counter back to zero
    logic push_single;   // load one event result into the output register
    logic push_reading;  // load the reading at the counter, then advance
  } cmd_t;

  typedef struct packed {
    logic     byte_is_station;
    logic     len_zero;      // length bytes give zero (valid in low length phase)
    logic     payload_done;  // this payload byte is the last one
    verdict_e verdict;
    logic     emit_last;
    logic     out_free;      // output register can take a result this cycle
  } stat_t;

endpackage

// File: rtl/spd_stream_if.sv
// Valid/ready channels of the deframer: received bytes in, results out.
// Depends on nothing but the field widths of the block.
`timescale 1ns / 1ps

interface spd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface spd_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [7:0]  reading;
  logic [4:0]  sensor_index;
  logic [15:0] frame_number;
  logic [7:0]  ack_code;
  logic        last;

  modport source (output valid, output event_res, output reading, output sensor_index,
                  output frame_number, output ack_code, output last, input ready);
  modport sink (input valid, input event_res, input reading, input sensor_index,
                input frame_number, input ack_code, input last, output ready);
endinterface

// File: rtl/spd_ctrl.sv
// Controller of the deframer: packet phase tracking and result sequencing.
// Uses spd_pkg command/status structs; drives spd_dpath only through them.
`timescale 1ns / 1ps

module spd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  spd_pkg::stat_t stat_i,
  output spd_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_RX    = 3'b001,
    ST_JUDGE = 3'b010,
    ST_EMIT  = 3'b100
  } state_e;

  typedef enum logic [6:0] {
    PH_HUNT    = 7'b0000001,
    PH_CMD     = 7'b0000010,
    PH_LEN_HI  = 7'b0000100,
    PH_LEN_LO  = 7'b0001000,
    PH_PAYLOAD = 7'b0010000,
    PH_SUM_HI  = 7'b0100000,
    PH_SUM_LO  = 7'b1000000
  } phase_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic   acc;

  assign in_ready_o = (state_q == ST_RX);
  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o = '0;
    state_d = state_q;
    phase_d = phase_q;
    unique case (state_q)
      ST_RX: begin
        if (in_valid_i) begin
          unique case (phase_q)
            PH_CMD: begin
              cmd_o.ld_cmd = 1'b1;
              cmd_o.sum_add = 1'b1;
              phase_d = PH_LEN_HI;
            end
            PH_LEN_HI: begin
              cmd_o.ld_len_hi = 1'b1;
              cmd_o.sum_add = 1'b1;
              phase_d = PH_LEN_LO;
            end
            PH_LEN_LO: begin
              cmd_o.ld_len_lo = 1'b1;
              cmd_o.sum_add = 1'b1;
              phase_d = stat_i.len_zero ? PH_SUM_HI : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
              cmd_o.pay_byte = 1'b1;
              cmd_o.sum_add = 1'b1;
              if (stat_i.payload_done) phase_d = PH_SUM_HI;
            end
            PH_SUM_HI: begin
              cmd_o.ld_sum_hi = 1'b1;
              phase_d = PH_SUM_LO;
            end
            PH_SUM_LO: begin
              cmd_o.ld_sum_lo = 1'b1;
              phase_d = PH_HUNT;
              state_d = ST_JUDGE;
            end
            default: begin
              // hunting: anything but the station byte is dropped
              phase_d = PH_HUNT;
              if (stat_i.byte_is_station) begin
                cmd_o.sum_start = 1'b1;
                phase_d = PH_CMD;
              end
            end
          endcase
        end
      end
      ST_JUDGE: begin
        unique case (stat_i.verdict)
          spd_pkg::VK_SINGLE: begin
            if (stat_i.out_free) begin
              cmd_o.push_single = 1'b1;
              state_d = ST_RX;
            end
          end
          spd_pkg::VK_SWEEP: begin
            cmd_o.frame_update = 1'b1;
            cmd_o.emit_clear = 1'b1;
            state_d = ST_EMIT;
          end
          default: state_d = ST_RX;  // repeated frame: nothing to send
        endcase
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.push_reading = 1'b1;
          if (stat_i.emit_last) state_d = ST_RX;
        end
      end
      default: state_d = ST_RX;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RX;
      phase_q <= PH_HUNT;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

`ifndef ASSERT_OFF
  a_sum_lo_judges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && phase_q == PH_SUM_LO |=> state_q == ST_JUDGE)
    else $error("checksum low byte did not start judging");

  a_push_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.push_single || cmd_o.push_reading) |-> stat_i.out_free)
    else $error("result pushed into a full output register");

  a_emit_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT && cmd_o.push_reading && stat_i.emit_last |=> state_q == ST_RX)
    else $error("sweep burst did not end after the last reading");

  a_no_rx_cmd_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_RX |-> !(cmd_o.sum_add || cmd_o.sum_start || cmd_o.ld_sum_lo))
    else $error("byte command issued while not receiving");
`endif

endmodule

// File: rtl/spd_dpath.sv
// Datapath of the deframer: packet registers, checksum, reading store,
// packet verdict and the output register. Commanded by spd_ctrl via spd_pkg types.
`timescale 1ns / 1ps

module spd_dpath #(
  parameter int unsigned READINGS_PER_SWEEP = spd_pkg::READINGS_PER_SWEEP
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [7:0]     data_byte_i,
  input  logic [7:0]     max_range_i,
  input  spd_pkg::cmd_t  cmd_i,
  output spd_pkg::stat_t stat_o,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output logic [2:0]     event_res_o,
  output logic [7:0]     reading_o,
  output logic [4:0]     sensor_index_o,
  output logic [15:0]    frame_number_o,
  output logic [7:0]     ack_code_o,
  output logic           last_o
);

  localparam int unsigned IDX_W = (READINGS_PER_SWEEP > 1) ? $clog2(READINGS_PER_SWEEP) : 1;
  localparam logic [15:0] SWEEP_LEN = 16'(READINGS_PER_SWEEP + 2);
  localparam logic [15:0] STORE_DEPTH = 16'(READINGS_PER_SWEEP);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(READINGS_PER_SWEEP - 1);

  logic [7:0]  cmd_byte_q;
  logic [15:0] len_q;
  logic [15:0] count_q;
  logic [15:0] sum_q;
  logic [7:0]  sum_hi_q;
  logic [7:0]  sum_lo_q;
  logic [15:0] first_q;
  logic [15:0] prev_frame_q;
  logic        prev_valid_q;
  logic [7:0]  store_q [READINGS_PER_SWEEP];
  logic [IDX_W-1:0] emit_idx_q;

  logic        out_valid_q;
  spd_pkg::event_e out_event_q;
  logic [7:0]  out_reading_q;
  logic [4:0]  out_index_q;
  logic [15:0] out_frame_q;
  logic [7:0]  out_code_q;
  logic        out_last_q;

  logic [15:0] count_inc;
  logic [15:0] store_pos;
  logic        store_we;
  logic        sum_ok;
  spd_pkg::verdict_e verdict;
  spd_pkg::event_e   single_ev;
  logic [7:0]  single_code;
  logic [7:0]  raw_reading;
  logic [IDX_W+4:0] idx_ext;

  assign count_inc = count_q + 16'd1;
  assign store_pos = count_q - 16'd2;
  assign store_we = cmd_i.pay_byte && (count_q >= 16'd2) && (store_pos < STORE_DEPTH);
  assign sum_ok = ({sum_hi_q, sum_lo_q} == sum_q);

  // Packet verdict, evaluated on the registered packet after the last byte
  always_comb begin
    verdict = spd_pkg::VK_SINGLE;
    single_ev = spd_pkg::EV_UNKNOWN_CMD;
    single_code = 8'h00;
    priority if (!sum_ok) begin
      single_ev = spd_pkg::EV_BAD_SUM;
    end else if (cmd_byte_q == spd_pkg::CMD_ACK) begin
      if (len_q != spd_pkg::ACK_LEN) begin
        single_ev = spd_pkg::EV_BAD_LEN;
      end else begin
        single_code = first_q[7:0];
        priority if (first_q[7:0] == spd_pkg::ACK_CODE_OK) single_ev = spd_pkg::EV_ACK_OK;
        else if (first_q[7:0] == spd_pkg::ACK_CODE_ILLEGAL) single_ev = spd_pkg::EV_ACK_ILLEGAL;
        else if (first_q[7:0] == spd_pkg::ACK_CODE_BAD_SUM) single_ev = spd_pkg::EV_ACK_BAD_SUM;
        else single_ev = spd_pkg::EV_ACK_OTHER;
      end
    end else if (cmd_byte_q == spd_pkg::CMD_SWEEP) begin
      if (len_q != SWEEP_LEN) begin
        single_ev = spd_pkg::EV_BAD_LEN;
      end else if (prev_valid_q && first_q == prev_frame_q) begin
        verdict = spd_pkg::VK_NONE;
      end else begin
        verdict = spd_pkg::VK_SWEEP;
      end
    end else begin
      single_ev = spd_pkg::EV_UNKNOWN_CMD;
    end
  end

  assign raw_reading = store_q[emit_idx_q];
  assign idx_ext = {5'b00000, emit_idx_q};

  assign stat_o.byte_is_station = (data_byte_i == spd_pkg::STATION_BYTE);
  assign stat_o.len_zero = (len_q[15:8] == 8'h00) && (data_byte_i == 8'h00);
  assign stat_o.payload_done = (count_inc >= len_q);
  assign stat_o.verdict = verdict;
  assign stat_o.emit_last = (emit_idx_q == LAST_IDX);
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_byte_q <= 8'h00;
      len_q <= 16'h0000;
      count_q <= 16'h0000;
      sum_q <= 16'h0000;
      sum_hi_q <= 8'h00;
      sum_lo_q <= 8'h00;
      first_q <= 16'h0000;
      prev_frame_q <= 16'h0000;
      prev_valid_q <= 1'b0;
      emit_idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.sum_start) sum_q <= {8'h00, data_byte_i};
      else if (cmd_i.sum_add) sum_q <= sum_q + {8'h00, data_byte_i};
      if (cmd_i.ld_cmd) cmd_byte_q <= data_byte_i;
      if (cmd_i.ld_len_hi) len_q <= {data_byte_i, 8'h00};
      if (cmd_i.ld_len_lo) begin
        len_q[7:0] <= data_byte_i;
        count_q <= 16'h0000;
        first_q <= 16'h0000;
      end
      if (cmd_i.pay_byte) begin
        count_q <= count_inc;
        if (count_q < 16'd2) first_q <= {first_q[7:0], data_byte_i};
      end
      if (cmd_i.ld_sum_hi) sum_hi_q <= data_byte_i;
      if (cmd_i.ld_sum_lo) sum_lo_q <= data_byte_i;
      if (cmd_i.frame_update) begin
        prev_frame_q <= first_q;
        prev_valid_q <= 1'b1;
      end
      if (cmd_i.emit_clear) emit_idx_q <= '0;
      else if (cmd_i.push_reading) emit_idx_q <= emit_idx_q + IDX_W'(1);
      if (cmd_i.push_single || cmd_i.push_reading) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // reading store: flops, written by payload position, read at the burst counter
  always_ff @(posedge clk_i) begin
    if (store_we) store_q[store_pos[IDX_W-1:0]] <= data_byte_i;
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (cmd_i.push_single) begin
      out_event_q <= single_ev;
      out_reading_q <= 8'h00;
      out_index_q <= 5'd0;
      out_frame_q <= 16'h0000;
      out_code_q <= single_code;
      out_last_q <= 1'b1;
    end else if (cmd_i.push_reading) begin
      out_event_q <= spd_pkg::EV_READING;
      out_reading_q <= (raw_reading == 8'h00) ? max_range_i : raw_reading;
      out_index_q <= idx_ext[4:0];
      out_frame_q <= first_q;
      out_code_q <= 8'h00;
      out_last_q <= (emit_idx_q == LAST_IDX);
    end
  end

  assign out_valid_o = out_valid_q;
  assign event_res_o = out_event_q;
  assign reading_o = out_reading_q;
  assign sensor_index_o = out_index_q;
  assign frame_number_o = out_frame_q;
  assign ack_code_o = out_code_q;
  assign last_o = out_last_q;

endmodule

// File: rtl/sonar_packet_deframer_top.sv
// Top level of the sonar packet deframer: APB register, controller and datapath.
// Depends on spd_pkg, spd_stream_if, spd_ctrl and spd_dpath.
`timescale 1ns / 1ps

// Sonar packet deframer. Bytes from the sonar link arrive on byte_i, one per
// transfer, and are taken at one per cycle while a packet is being received.
// After the second checksum byte the block judges the packet, during which
// byte_i is not ready. A good ack, a bad checksum, a bad length or an unknown
// command yields one result; a new sweep yields READINGS_PER_SWEEP readings,
// loaded into the output register at one per cycle as result_o takes them.
// byte_i stays blocked during the burst (the burst counter walks the reading
// store); it reopens as soon as the last result is in the output register, so
// bytes flow again while that result still waits on result_o. The sensor index
// is the low five bits of the reading position. max_range lives at byte address
// 0 on the APB port (reset 255) and replaces zero readings; write it only while
// the block is idle. Reads return the register; there is no reset sweep.

module sonar_packet_deframer_top #(
  parameter int unsigned READINGS_PER_SWEEP = spd_pkg::READINGS_PER_SWEEP
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  spd_byte_if.sink                        byte_i,
  spd_result_if.source                    result_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [spd_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [spd_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [spd_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  logic [7:0]     max_range_q;
  logic           reg_sel;
  spd_pkg::cmd_t  cmd;
  spd_pkg::stat_t stat;

  // Register file: a single 8-bit register, word-decoded on paddr[2]
  assign pready = 1'b1;
  assign reg_sel = (paddr[spd_pkg::APB_ADDR_W-1:2] == spd_pkg::REG_MAX_RANGE);
  assign prdata = reg_sel ? spd_pkg::APB_DATA_W'(max_range_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_range_q <= spd_pkg::MAX_RANGE_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      max_range_q <= pwdata[7:0];
    end
  end

  spd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (byte_i.valid),
    .in_ready_o (byte_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  spd_dpath #(
    .READINGS_PER_SWEEP (READINGS_PER_SWEEP)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .data_byte_i    (byte_i.data_byte),
    .max_range_i    (max_range_q),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_ready_i    (result_o.ready),
    .out_valid_o    (result_o.valid),
    .event_res_o    (result_o.event_res),
    .reading_o      (result_o.reading),
    .sensor_index_o (result_o.sensor_index),
    .frame_number_o (result_o.frame_number),
    .ack_code_o     (result_o.ack_code),
    .last_o         (result_o.last)
  );

endmodule

// File: sim/sonar_packet_deframer_top_tb.sv
// Testbench of the sonar packet deframer: directed and random byte streams in,
// result transfers checked field by field against a transaction-level predictor.
// Depends on spd_pkg, spd_stream_if and sonar_packet_deframer_top.
`timescale 1ns / 1ps

module sonar_packet_deframer_top_tb;
  import spd_pkg::*;

  localparam int unsigned SWEEP_LEN = READINGS_PER_SWEEP + 2;
  localparam logic [APB_ADDR_W-1:0] ADDR_MAX_RANGE = {REG_MAX_RANGE, 2'b00};
  // Covers the judge cycle and a full reading burst with a stalling sink.
  localparam int unsigned SETTLE_CYCLES = 80;

  // Receive phases of the predictor
  typedef enum logic [2:0] {
    LK_HUNT, LK_CMD, LK_LEN_HI, LK_LEN_LO, LK_PAYLOAD, LK_SUM_HI, LK_SUM_LO
  } link_phase_e;

  typedef enum int unsigned {
    PK_SWEEP, PK_ACK, PK_BAD_SUM, PK_BAD_LEN, PK_UNKNOWN, PK_NOISE
  } packet_kind_e;

  typedef struct packed {
    event_e      ev;
    logic [7:0]  reading;
    logic [4:0]  index;
    logic [15:0] frame;
    logic [7:0]  code;
    logic        last;
  } sonar_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel, penable, pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata, prdata;
  logic                  pready;

  spd_byte_if   byte_if ();
  spd_result_if res_if ();

  sonar_packet_deframer_top u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_if),
    .result_o (res_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #2 clk_i = ~clk_i;

  // Traffic: bytes waiting for the link, results waiting for the sink
  logic [7:0]    link_bytes[$];
  sonar_result_t expected_results[$];
  logic [7:0]    pkt_q[$];
  int unsigned   send_gap_pct = 0;
  int unsigned   sink_stall_pct = 0;
  int unsigned   fault_count = 0;
  logic          byte_fire = 1'b0;

  // Predictor state
  link_phase_e lk_phase = LK_HUNT;
  logic [7:0]  lk_cmd = '0;
  logic [15:0] lk_len = '0;
  logic [15:0] lk_count = '0;
  logic [15:0] lk_sum = '0;
  logic [7:0]  lk_sum_hi = '0;
  logic [7:0]  lk_ranges[READINGS_PER_SWEEP];
  logic [15:0] lk_head = '0;
  logic [15:0] lk_prev_frame = '0;
  logic        lk_prev_seen = 1'b0;
  logic [7:0]  lk_max_range = MAX_RANGE_RESET;

  // Generator memory of the last good sweep frame, for repeats
  logic [15:0] gen_frame = '0;
  bit          gen_frame_seen = 1'b0;

  function automatic void push_event(event_e ev, logic [7:0] code);
    sonar_result_t r;
    r = '{ev: ev, reading: 8'd0, index: 5'd0, frame: 16'd0, code: code, last: 1'b1};
    expected_results.push_back(r);
  endfunction

  function automatic void judge_packet(logic [7:0] sum_lo);
    sonar_result_t r;
    logic [7:0]    code;
    code = lk_head[7:0];
    if ({lk_sum_hi, sum_lo} != lk_sum) begin
      push_event(EV_BAD_SUM, 8'd0);
    end else if (lk_cmd == CMD_ACK) begin
      if (lk_len != ACK_LEN) push_event(EV_BAD_LEN, 8'd0);
      else if (code == ACK_CODE_OK) push_event(EV_ACK_OK, code);
      else if (code == ACK_CODE_ILLEGAL) push_event(EV_ACK_ILLEGAL, code);
      else if (code == ACK_CODE_BAD_SUM) push_event(EV_ACK_BAD_SUM, code);
      else push_event(EV_ACK_OTHER, code);
    end else if (lk_cmd == CMD_SWEEP) begin
      if (lk_len != SWEEP_LEN) begin
        push_event(EV_BAD_LEN, 8'd0);
      end else if (!(lk_prev_seen && lk_head == lk_prev_frame)) begin
        // new frame: emit the whole sweep, zero means no echo
        lk_prev_frame = lk_head;
        lk_prev_seen = 1'b1;
        for (int i = 0; i < READINGS_PER_SWEEP; i++) begin
          r.ev = EV_READING;
          r.reading = (lk_ranges[i] == 8'd0) ? lk_max_range : lk_ranges[i];
          r.index = 5'(i);
          r.frame = lk_head;
          r.code = 8'd0;
          r.last = (i == READINGS_PER_SWEEP - 1);
          expected_results.push_back(r);
        end
      end
    end else begin
      push_event(EV_UNKNOWN_CMD, 8'd0);
    end
  endfunction

  function automatic void deframe_byte(logic [7:0] b);
    int slot;
    slot = int'(lk_count) - 2;
    case (lk_phase)
      LK_CMD: begin
        lk_cmd = b;
        lk_sum = lk_sum + 16'(b);
        lk_phase = LK_LEN_HI;
      end
      LK_LEN_HI: begin
        lk_len = {b, 8'h00};
        lk_sum = lk_sum + 16'(b);
        lk_phase = LK_LEN_LO;
      end
      LK_LEN_LO: begin
        lk_len[7:0] = b;
        lk_sum = lk_sum + 16'(b);
        lk_count = '0;
        lk_head = '0;
        lk_phase = (lk_len == 16'd0) ? LK_SUM_HI : LK_PAYLOAD;
      end
      LK_PAYLOAD: begin
        lk_sum = lk_sum + 16'(b);
        if (lk_count < 16'd2) lk_head = {lk_head[7:0], b};
        else if (slot < READINGS_PER_SWEEP) lk_ranges[slot] = b;
        lk_count = lk_count + 16'd1;
        if (lk_count >= lk_len) lk_phase = LK_SUM_HI;
      end
      LK_SUM_HI: begin
        lk_sum_hi = b;
        lk_phase = LK_SUM_LO;
      end
      LK_SUM_LO: begin
        lk_phase = LK_HUNT;
        judge_packet(b);
      end
      default: begin
        if (b == STATION_BYTE) begin
          lk_sum = {8'h00, b};
          lk_phase = LK_CMD;
        end else begin
          lk_phase = LK_HUNT;
        end
      end
    endcase
  endfunction

  // Byte driver: holds a byte until its transfer, idles at random between bytes
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!byte_if.valid || byte_fire) begin
        if (link_bytes.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          byte_if.data_byte <= link_bytes.pop_front();
          byte_if.valid <= 1'b1;
        end else begin
          byte_if.valid <= 1'b0;
        end
      end
      res_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // Monitor: predicts on each byte transfer, checks each result transfer
  always @(posedge clk_i) begin : monitor
    sonar_result_t want;
    byte_fire <= byte_if.valid && byte_if.ready;
    if (rst_ni && byte_if.valid && byte_if.ready) deframe_byte(byte_if.data_byte);
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing pending: event_res %0d", res_if.event_res);
        fault_count++;
      end else begin
        want = expected_results.pop_front();
        if (res_if.event_res !== want.ev) begin
          $error("event_res: expected %0d, got %0d", want.ev, res_if.event_res);
          fault_count++;
        end
        if (res_if.reading !== want.reading) begin
          $error("reading: expected %0d, got %0d", want.reading, res_if.reading);
          fault_count++;
        end
        if (res_if.sensor_index !== want.index) begin
          $error("sensor_index: expected %0d, got %0d", want.index, res_if.sensor_index);
          fault_count++;
        end
        if (res_if.frame_number !== want.frame) begin
          $error("frame_number: expected %0d, got %0d", want.frame, res_if.frame_number);
          fault_count++;
        end
        if (res_if.ack_code !== want.code) begin
          $error("ack_code: expected %0d, got %0d", want.code, res_if.ack_code);
          fault_count++;
        end
        if (res_if.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, res_if.last);
          fault_count++;
        end
      end
    end
  end

  task automatic write_max_range(logic [7:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_MAX_RANGE;
    pwdata <= {24'($urandom()), value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    lk_max_range = value;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Wait until every byte is taken and every result is in, then let it settle.
  task automatic drain_link();
    while (link_bytes.size() != 0 || byte_if.valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic open_packet(logic [7:0] cmd, logic [15:0] len);
    pkt_q.delete();
    pkt_q.push_back(STATION_BYTE);
    pkt_q.push_back(cmd);
    pkt_q.push_back(len[15:8]);
    pkt_q.push_back(len[7:0]);
  endtask

  task automatic close_packet(bit corrupt);
    logic [15:0] sum;
    sum = '0;
    for (int k = 0; k < pkt_q.size(); k++) sum = sum + 16'(pkt_q[k]);
    if (corrupt) sum = sum ^ 16'($urandom_range(1, 16'hFFFF));
    pkt_q.push_back(sum[15:8]);
    pkt_q.push_back(sum[7:0]);
    for (int k = 0; k < pkt_q.size(); k++) link_bytes.push_back(pkt_q[k]);
  endtask

  task automatic fill_random(int unsigned n);
    repeat (n) pkt_q.push_back(8'($urandom()));
  endtask

  // Frame number, then readings with plenty of no-echo zeros
  task automatic sweep_body(logic [15:0] frame);
    pkt_q.push_back(frame[15:8]);
    pkt_q.push_back(frame[7:0]);
    repeat (READINGS_PER_SWEEP)
      pkt_q.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom()));
  endtask

  function automatic logic [15:0] pick_frame();
    case ($urandom_range(0, 7))
      0, 1: return gen_frame_seen ? gen_frame : 16'h0000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [7:0] pick_code();
    case ($urandom_range(0, 4))
      0: return ACK_CODE_OK;
      1: return ACK_CODE_ILLEGAL;
      2: return ACK_CODE_BAD_SUM;
      default: return 8'($urandom());
    endcase
  endfunction

  task automatic queue_packet(packet_kind_e kind);
    logic [15:0] f;
    logic [7:0]  cmd;
    int unsigned n;
    case (kind)
      PK_SWEEP: begin
        f = pick_frame();
        open_packet(CMD_SWEEP, 16'(SWEEP_LEN));
        sweep_body(f);
        close_packet(1'b0);
        gen_frame = f;
        gen_frame_seen = 1'b1;
      end
      PK_ACK: begin
        open_packet(CMD_ACK, ACK_LEN);
        pkt_q.push_back(pick_code());
        close_packet(1'b0);
      end
      PK_BAD_SUM: begin
        case ($urandom_range(0, 2))
          0: begin
            open_packet(CMD_ACK, ACK_LEN);
            pkt_q.push_back(pick_code());
          end
          1: begin
            open_packet(CMD_SWEEP, 16'(SWEEP_LEN));
            sweep_body(16'($urandom()));
          end
          default: begin
            n = $urandom_range(0, 3);
            open_packet(8'($urandom()), 16'(n));
            fill_random(n);
          end
        endcase
        close_packet(1'b1);
      end
      PK_BAD_LEN: begin
        if ($urandom_range(0, 1) == 0) begin
          cmd = CMD_ACK;
          n = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(2, 4);
        end else begin
          cmd = CMD_SWEEP;
          case ($urandom_range(0, 2))
            0: n = SWEEP_LEN - 1;
            1: n = SWEEP_LEN + 1;
            default: n = $urandom_range(0, 3);
          endcase
        end
        open_packet(cmd, 16'(n));
        fill_random(n);
        close_packet(1'b0);
      end
      PK_UNKNOWN: begin
        do cmd = 8'($urandom()); while (cmd == CMD_ACK || cmd == CMD_SWEEP);
        n = $urandom_range(0, 4);
        open_packet(cmd, 16'(n));
        fill_random(n);
        close_packet(1'b0);
      end
      default: begin
        // line noise: never the station byte, so no packet is started
        repeat ($urandom_range(1, 3)) begin
          do cmd = 8'($urandom()); while (cmd == STATION_BYTE);
          link_bytes.push_back(cmd);
        end
      end
    endcase
  endtask

  // Mostly well-formed packets with random content, some broken ones and noise
  task automatic queue_traffic(int unsigned goal);
    int unsigned base;
    int unsigned r;
    base = link_bytes.size();
    while (link_bytes.size() - base < goal) begin
      r = $urandom_range(0, 99);
      if (r < 40) queue_packet(PK_SWEEP);
      else if (r < 55) queue_packet(PK_ACK);
      else if (r < 65) queue_packet(PK_BAD_SUM);
      else if (r < 75) queue_packet(PK_BAD_LEN);
      else if (r < 85) queue_packet(PK_UNKNOWN);
      else queue_packet(PK_NOISE);
    end
  endtask

  initial begin
    int unsigned gap_pct[4];
    int unsigned stall_pct[4];
    int unsigned goal_bytes[4];
    logic [7:0]  range_val[4];
    gap_pct = '{0, 45, 0, 18};
    stall_pct = '{0, 0, 45, 18};
    goal_bytes = '{0, 10, 10, 10};
    range_val = '{8'h00, 8'hFF, 8'($urandom_range(2, 254)), 8'h01};

    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    byte_if.valid = 1'b0;
    byte_if.data_byte = 8'h00;
    res_if.ready = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: noise at the byte extremes, an ack, an empty packet
    // with an unknown command (checksum right after the length)
    link_bytes.push_back(8'h00);
    link_bytes.push_back(8'hFF);
    link_bytes.push_back(8'h80);
    open_packet(CMD_ACK, ACK_LEN);
    pkt_q.push_back(ACK_CODE_OK);
    close_packet(1'b0);
    open_packet(8'h00, 16'h0000);
    close_packet(1'b0);
    drain_link();

    for (int p = 0; p < 4; p++) begin
      send_gap_pct = gap_pct[p];
      sink_stall_pct = stall_pct[p];
      write_max_range(range_val[p]);
      if (p == 0) begin
        // first sweep carries frame 0 with no frame seen yet, then a repeat
        open_packet(CMD_SWEEP, 16'(SWEEP_LEN));
        sweep_body(16'h0000);
        close_packet(1'b0);
        gen_frame = 16'h0000;
        gen_frame_seen = 1'b1;
        open_packet(CMD_SWEEP, 16'(SWEEP_LEN));
        sweep_body(16'h0000);
        close_packet(1'b0);
        // long payload: bytes past the reading store are summed, not kept
        open_packet(CMD_SWEEP, 16'h001C);
        repeat (16'h001C) pkt_q.push_back(8'hFF);
        close_packet(1'b0);
      end
      queue_traffic(goal_bytes[p]);
      drain_link();
    end

    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
